### src/rbv_pkg.sv
// rbv_pkg: shared types, sizes and codes of the rank bit vector builder
// used by rbv_front, rbv_queue, rbv_back and rank_bitvector_builder
package rbv_pkg;

  localparam int LOG_MAX_BITS = 18;
  localparam int SUPER_LOG    = 16;
  localparam int BUCKET_LOG   = 4;

  localparam int COUNT_W    = LOG_MAX_BITS + 1;
  localparam int WORD_W     = 1 << BUCKET_LOG;
  localparam int WIDX_W     = LOG_MAX_BITS - BUCKET_LOG;
  localparam int SUP_W      = LOG_MAX_BITS - SUPER_LOG;
  localparam int NUM_WORDS  = 1 << WIDX_W;
  localparam int NUM_SUPERS = 1 << SUP_W;
  localparam int BZ_W       = 16;
  localparam int BND_W      = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_RANK  = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_LOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_HIGH = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [7:0]  data_byte;
    logic               which_bit;
    logic [COUNT_W-1:0] position;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] answer;
    logic               kept;
    logic [COUNT_W-1:0] bits_loaded;
    logic               error;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_PLAIN = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_RANK  = 2'd2,
    CMD_READ  = 2'd3
  } cmd_kind_t;

  // work handed from the front to the back
  typedef struct packed {
    cmd_kind_t            kind;
    logic                 kept;
    logic [COUNT_W-1:0]   bits_loaded;
    logic                 error;
    logic [WIDX_W-1:0]    widx;
    logic [BUCKET_LOG-1:0] bitsel;
    logic [WORD_W-1:0]    word;
    logic                 bz_we;
    logic [BZ_W-1:0]      bz_val;
    logic [COUNT_W-1:0]   base;
    logic [COUNT_W-1:0]   pos;
    logic                 which;
    logic                 direct;
  } cmd_t;

endpackage

### src/rbv_front.sv
// rbv_front: accepts items, holds the bounds, the counters and the superbucket table,
// and turns each item into a back-end command; depends on rbv_pkg
module rbv_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rbv_pkg::in_item_t                 in_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rbv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rbv_pkg::BND_W-1:0]         cfg_data,
  input  logic                              q_full,
  output logic                              push,
  output rbv_pkg::cmd_t                     push_cmd
);
  import rbv_pkg::*;

  logic signed [BND_W-1:0] zero_low_bound;
  logic signed [BND_W-1:0] one_low_bound;
  logic signed [BND_W-1:0] one_high_bound;

  logic [COUNT_W-1:0] bit_count, bit_count_next;
  logic [COUNT_W-1:0] zero_count, zero_count_next;
  logic [COUNT_W-1:0] superbucket_base, superbucket_base_next;
  logic [WORD_W-1:0]  current_word, current_word_next;
  logic [COUNT_W-1:0] super_counts [NUM_SUPERS];
  logic               super_we;

  logic signed [BND_W-1:0] byte_ext;
  logic                    keep, is_zero, super_start, bucket_start;
  logic [WORD_W-1:0]       word_base;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;

  assign byte_ext     = {in_data.data_byte[7], in_data.data_byte};
  assign keep         = (zero_low_bound <= byte_ext) && (byte_ext < one_high_bound);
  assign is_zero      = (zero_low_bound <= byte_ext) && (byte_ext < one_low_bound);
  assign super_start  = bit_count[SUPER_LOG-1:0] == '0;
  assign bucket_start = bit_count[BUCKET_LOG-1:0] == '0;
  assign word_base    = bucket_start ? '0 : current_word;

  always_comb begin
    bit_count_next        = bit_count;
    zero_count_next       = zero_count;
    superbucket_base_next = superbucket_base;
    current_word_next     = current_word;
    super_we              = 1'b0;
    push_cmd              = '0;
    push_cmd.kind         = CMD_PLAIN;
    push_cmd.bits_loaded  = bit_count;
    push_cmd.pos          = in_data.position;
    push_cmd.which        = in_data.which_bit;
    push_cmd.widx         = in_data.position[LOG_MAX_BITS-1:BUCKET_LOG];
    push_cmd.bitsel       = in_data.position[BUCKET_LOG-1:0];
    unique case (in_data.operation)
      OP_CLEAR: begin
        bit_count_next        = '0;
        zero_count_next       = '0;
        superbucket_base_next = '0;
        current_word_next     = '0;
        push_cmd.bits_loaded  = '0;
      end
      OP_LOAD: begin
        if (keep && bit_count[LOG_MAX_BITS]) begin
          push_cmd.error = 1'b1;
        end else if (keep) begin
          if (super_start) begin
            superbucket_base_next = zero_count;
            super_we              = 1'b1;
          end
          current_word_next = is_zero ? word_base
                            : (word_base | (WORD_W'(1) << bit_count[BUCKET_LOG-1:0]));
          if (is_zero) begin
            zero_count_next = zero_count + COUNT_W'(1);
          end
          bit_count_next       = bit_count + COUNT_W'(1);
          push_cmd.kind        = CMD_LOAD;
          push_cmd.kept        = 1'b1;
          push_cmd.bits_loaded = bit_count_next;
          push_cmd.widx        = bit_count[LOG_MAX_BITS-1:BUCKET_LOG];
          push_cmd.word        = current_word_next;
          push_cmd.bz_we       = bucket_start;
          push_cmd.bz_val      = BZ_W'(zero_count - superbucket_base_next);
        end
      end
      OP_RANK: begin
        if (in_data.position > bit_count) begin
          push_cmd.error = 1'b1;
        end else begin
          push_cmd.kind   = CMD_RANK;
          push_cmd.direct = in_data.position == bit_count;
          push_cmd.base   = (in_data.position == bit_count) ? zero_count
                          : super_counts[in_data.position[LOG_MAX_BITS-1:SUPER_LOG]];
        end
      end
      OP_READ: begin
        if (in_data.position >= bit_count) begin
          push_cmd.error = 1'b1;
        end else begin
          push_cmd.kind = CMD_READ;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_low_bound   <= -BND_W'(128);
      one_low_bound    <= '0;
      one_high_bound   <= BND_W'(128);
      bit_count        <= '0;
      zero_count       <= '0;
      superbucket_base <= '0;
      current_word     <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ZERO_LOW: zero_low_bound <= cfg_data;
          CFG_ONE_LOW:  one_low_bound  <= cfg_data;
          CFG_ONE_HIGH: one_high_bound <= cfg_data;
          default: ;
        endcase
      end
      if (push) begin
        bit_count        <= bit_count_next;
        zero_count       <= zero_count_next;
        superbucket_base <= superbucket_base_next;
        current_word     <= current_word_next;
      end
    end
  end

  // superbucket table, written at the first bit of each superbucket
  always_ff @(posedge clk) begin
    if (push && super_we) begin
      super_counts[bit_count[LOG_MAX_BITS-1:SUPER_LOG]] <= zero_count;
    end
  end

endmodule

### src/rbv_queue.sv
// rbv_queue: short command queue between front and back
// depends on rbv_pkg for the command type and depth
module rbv_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rbv_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output rbv_pkg::cmd_t head
);
  import rbv_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   fill;

  assign full  = fill == (PTR_W+1)'(QUEUE_DEPTH);
  assign empty = fill == '0;
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        fill <= fill + (PTR_W+1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (PTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

### src/rbv_back.sv
// rbv_back: bucket word and bucket count memories, rank and bit read datapath,
// and the output register; depends on rbv_pkg
module rbv_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  rbv_pkg::cmd_t      head,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output rbv_pkg::out_item_t out_data
);
  import rbv_pkg::*;

  logic [WORD_W-1:0] bit_words          [NUM_WORDS];
  logic [BZ_W-1:0]   bucket_zero_counts [NUM_WORDS];

  logic              a_valid;
  cmd_t              a_cmd;
  logic [WORD_W-1:0] rd_word;
  logic [BZ_W-1:0]   rd_bz;
  logic              adv;

  logic [WORD_W-1:0]  low_mask;
  logic [COUNT_W-1:0] zeros;
  out_item_t          result;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_LOAD) begin
      bit_words[head.widx] <= head.word;
    end
    if (pop && (head.kind == CMD_RANK || head.kind == CMD_READ)) begin
      rd_word <= bit_words[head.widx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head.kind == CMD_LOAD && head.bz_we) begin
      bucket_zero_counts[head.widx] <= head.bz_val;
    end
    if (pop && head.kind == CMD_RANK) begin
      rd_bz <= bucket_zero_counts[head.widx];
    end
  end

  // zeros before the position: directory entries plus zeros in the low part of the word
  assign low_mask = (WORD_W'(1) << a_cmd.bitsel) - WORD_W'(1);
  assign zeros = a_cmd.direct ? a_cmd.base
               : a_cmd.base + COUNT_W'(rd_bz) + COUNT_W'(a_cmd.bitsel)
                 - COUNT_W'($countones(rd_word & low_mask));

  always_comb begin
    result             = '0;
    result.kept        = a_cmd.kept;
    result.bits_loaded = a_cmd.bits_loaded;
    result.error       = a_cmd.error;
    unique case (a_cmd.kind)
      CMD_RANK: result.answer = a_cmd.which ? a_cmd.pos - zeros : zeros;
      CMD_READ: result.answer = COUNT_W'(rd_word[a_cmd.bitsel]);
      default:  result.answer = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= pop;
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= result;
      if (pop) begin
        a_cmd <= head;
      end
    end
  end

endmodule

### src/rank_bitvector_builder.sv
// rank_bitvector_builder: top level of the rank bit vector builder
// depends on rbv_pkg, rbv_front, rbv_queue and rbv_back
//
//   channel  signals                               transaction when
//   in       in_valid, in_stall, in_data           in_valid && !in_stall
//   out      out_valid, out_stall, out_data        out_valid && !out_stall
//   cfg      cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready
//
// one item per cycle sustained while out is not stalled; the front updates the counters
// at accept and the back does at most one read or write per item on the bucket word
// memory; an accepted item is registered in the queue, then a_cmd, then out_data.
// reset clears the counters and bounds; the memories are not cleared and hold stale
// entries that are always rewritten before a query can reach them.
// a stall on out backs up the queue; in_stall rises once the four-entry queue is full.
module rank_bitvector_builder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  rbv_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output rbv_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rbv_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rbv_pkg::BND_W-1:0]     cfg_data
);
  import rbv_pkg::*;

  logic q_full, q_empty, push, pop;
  cmd_t push_cmd, head;

  rbv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  rbv_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  rbv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
